// ----- rtl/point_rigid_transform_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the point transform RTL.
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POINT_RIGID_TRANSFORM_MACROS_SVH
`define POINT_RIGID_TRANSFORM_MACROS_SVH

// Same-cycle implication.
`define PRT_ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define PRT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/prt_pkg.sv -----
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and constants of the rigid point transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prt_pkg;

    localparam int QUAT_W = 32;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    // Register map, in word units.
    typedef enum logic [2:0] {
        REG_QUAT_X  = 3'd0,
        REG_QUAT_Y  = 3'd1,
        REG_QUAT_Z  = 3'd2,
        REG_QUAT_W  = 3'd3,
        REG_TRANS_X = 3'd4,
        REG_TRANS_Y = 3'd5,
        REG_TRANS_Z = 3'd6
    } reg_idx_t;

    typedef logic signed [31:0] mat_entry_t;
    typedef mat_entry_t mat_t [9];

    // Quaternion components x, y, z, w in elements 0 to 3.
    typedef logic [3:0][QUAT_W-1:0] quat_vec_t;

    typedef struct packed {
        logic busy;
        logic bad;
    } bld_status_t;

endpackage

// ----- rtl/prt_mat_build.sv -----
// ----------------------------------------------------------------------------
// prt_mat_build
// Builds the rotation matrix from the quaternion with one shared multiplier
// and one restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_rigid_transform_macros.svh"

module prt_mat_build (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  quat_we,
    input  prt_pkg::quat_vec_t    quat,
    output prt_pkg::mat_t         mat,
    output prt_pkg::bld_status_t  status
);
    import prt_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_NORM,
        B_SETUP,
        B_DIV,
        B_STORE
    } bstate_t;

    bstate_t     state_reg, state_next;
    logic [3:0]  idx_reg, idx_next;
    logic [3:0]  ent_reg, ent_next;
    logic [5:0]  step_reg, step_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] sq_reg [4];
    logic [63:0] sq_next [4];
    logic [63:0] cr_reg [6];
    logic [63:0] cr_next [6];
    logic [64:0] n_reg, n_next;
    logic [65:0] rem_reg, rem_next;
    logic [32:0] q_reg, q_next;
    logic        neg_reg, neg_next;
    logic        diag_reg, diag_next;
    logic        bad_reg, bad_next;
    mat_entry_t  mat_reg [9];
    mat_entry_t  mat_next [9];

    logic [31:0] mag [4];
    logic [31:0] op_a, op_b;
    logic [63:0] m1, m2, dsum;
    logic        sa, sb, sc, sd, flip, is_diag;
    logic [65:0] rem_sh;
    logic        qbit;
    logic [33:0] q_inc;
    logic [32:0] rmag;
    logic signed [33:0] entry;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = quat[i][31] ? (~quat[i] + 32'd1) : quat[i];
        end
    end

    // Operand pairs: four squares, then xy, zw, xz, yw, yz, xw.
    always_comb
    begin
        case (idx_reg)
            4'd0:    begin op_a = mag[0]; op_b = mag[0]; end
            4'd1:    begin op_a = mag[1]; op_b = mag[1]; end
            4'd2:    begin op_a = mag[2]; op_b = mag[2]; end
            4'd3:    begin op_a = mag[3]; op_b = mag[3]; end
            4'd4:    begin op_a = mag[0]; op_b = mag[1]; end
            4'd5:    begin op_a = mag[2]; op_b = mag[3]; end
            4'd6:    begin op_a = mag[0]; op_b = mag[2]; end
            4'd7:    begin op_a = mag[1]; op_b = mag[3]; end
            4'd8:    begin op_a = mag[1]; op_b = mag[2]; end
            4'd9:    begin op_a = mag[0]; op_b = mag[3]; end
            default: begin op_a = '0;     op_b = '0;     end
        endcase
    end

    // Per-entry numerator terms and signs, row-major order.
    always_comb
    begin
        m1 = '0; m2 = '0; dsum = '0;
        sa = 1'b0; sb = 1'b0; sc = 1'b0; sd = 1'b0; flip = 1'b0; is_diag = 1'b0;
        case (ent_reg)
            4'd0: begin is_diag = 1'b1; dsum = sq_reg[1] + sq_reg[2]; end
            4'd1: begin m1 = cr_reg[0]; m2 = cr_reg[1]; flip = 1'b1;
                  sa = quat[0][31]; sb = quat[1][31]; sc = quat[2][31]; sd = quat[3][31]; end
            4'd2: begin m1 = cr_reg[2]; m2 = cr_reg[3];
                  sa = quat[0][31]; sb = quat[2][31]; sc = quat[1][31]; sd = quat[3][31]; end
            4'd3: begin m1 = cr_reg[0]; m2 = cr_reg[1];
                  sa = quat[0][31]; sb = quat[1][31]; sc = quat[2][31]; sd = quat[3][31]; end
            4'd4: begin is_diag = 1'b1; dsum = sq_reg[0] + sq_reg[2]; end
            4'd5: begin m1 = cr_reg[4]; m2 = cr_reg[5]; flip = 1'b1;
                  sa = quat[1][31]; sb = quat[2][31]; sc = quat[0][31]; sd = quat[3][31]; end
            4'd6: begin m1 = cr_reg[2]; m2 = cr_reg[3]; flip = 1'b1;
                  sa = quat[0][31]; sb = quat[2][31]; sc = quat[1][31]; sd = quat[3][31]; end
            4'd7: begin m1 = cr_reg[4]; m2 = cr_reg[5];
                  sa = quat[1][31]; sb = quat[2][31]; sc = quat[0][31]; sd = quat[3][31]; end
            4'd8: begin is_diag = 1'b1; dsum = sq_reg[0] + sq_reg[1]; end
            default: ;
        endcase
    end

    assign rem_sh = (step_reg == '0) ? rem_reg : {rem_reg[64:0], 1'b0};
    assign qbit   = (rem_sh >= {1'b0, n_reg});
    assign q_inc  = {1'b0, q_reg} + 34'd1;
    assign rmag   = q_inc[33:1];
    assign entry  = diag_reg ? (34'(ONE_Q30) - $signed({1'b0, rmag}))
                             : (neg_reg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag}));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ent_next   = ent_reg;
        step_next  = step_reg;
        prod_next  = prod_reg;
        sq_next    = sq_reg;
        cr_next    = cr_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        neg_next   = neg_reg;
        diag_next  = diag_reg;
        bad_next   = bad_reg;
        mat_next   = mat_reg;
        case (state_reg)
            B_IDLE: ;
            B_MUL:
            begin
                prod_next = op_a * op_b;
                if (idx_reg != 4'd0)
                begin
                    if (idx_reg <= 4'd4)
                    begin
                        sq_next[2'(idx_reg - 4'd1)] = prod_reg;
                    end
                    else
                    begin
                        cr_next[3'(idx_reg - 4'd5)] = prod_reg;
                    end
                end
                if (idx_reg == 4'd10)
                begin
                    state_next = B_NORM;
                end
                idx_next = idx_reg + 4'd1;
            end
            B_NORM:
            begin
                n_next = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]}
                       + {1'b0, sq_reg[2]} + {1'b0, sq_reg[3]};
                if (n_next == '0)
                begin
                    bad_next   = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    bad_next   = 1'b0;
                    ent_next   = '0;
                    state_next = B_SETUP;
                end
            end
            B_SETUP:
            begin
                diag_next = is_diag;
                if (is_diag)
                begin
                    rem_next = {2'b00, dsum};
                    neg_next = 1'b0;
                end
                else if ((sa ^ sb) == (sc ^ sd ^ flip))
                begin
                    rem_next = {2'b00, m1 + m2};
                    neg_next = sa ^ sb;
                end
                else if (m1 >= m2)
                begin
                    rem_next = {2'b00, m1 - m2};
                    neg_next = sa ^ sb;
                end
                else
                begin
                    rem_next = {2'b00, m2 - m1};
                    neg_next = sc ^ sd ^ flip;
                end
                q_next     = '0;
                step_next  = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                rem_next  = qbit ? (rem_sh - {1'b0, n_reg}) : rem_sh;
                q_next    = {q_reg[31:0], qbit};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd32)
                begin
                    state_next = B_STORE;
                end
            end
            B_STORE:
            begin
                mat_next[ent_reg] = entry[31:0];
                ent_next = ent_reg + 4'd1;
                state_next = (ent_reg == 4'd8) ? B_IDLE : B_SETUP;
            end
            default: state_next = B_IDLE;
        endcase
        // A quaternion write restarts the build from scratch.
        if (quat_we)
        begin
            state_next = B_MUL;
            idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
            ent_reg   <= '0;
            step_reg  <= '0;
            bad_reg   <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                mat_reg[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ent_reg   <= ent_next;
            step_reg  <= step_next;
            bad_reg   <= bad_next;
            mat_reg   <= mat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sq_reg   <= sq_next;
        cr_reg   <= cr_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        neg_reg  <= neg_next;
        diag_reg <= diag_next;
    end

    assign mat         = mat_reg;
    assign status.busy = (state_reg != B_IDLE);
    assign status.bad  = bad_reg;

    `PRT_ASSERT_NEXT(a_we_restarts, quat_we, state_reg == B_MUL, "quaternion write did not restart build")
    `PRT_ASSERT_IMPLIES(a_rem_below, (state_reg == B_DIV) && (step_reg != '0), rem_reg < {1'b0, n_reg}, "divider remainder not below norm")
    `PRT_ASSERT_IMPLIES(a_norm_nonzero, state_reg == B_SETUP, n_reg != '0, "entry setup with zero norm")

endmodule

// ----- rtl/point_rigid_transform.sv -----
// ----------------------------------------------------------------------------
// point_rigid_transform
// Rotates each 3-D point by a quaternion and adds a translation.
// ----------------------------------------------------------------------------
// Usage:
// A point item is taken at a rising edge where start is high and busy is low.
// Point coordinates are signed Q15.16; the quaternion is signed Q1.30 and the
// translation signed Q15.16, both written through the APB port (quaternion
// x, y, z, w at word addresses 0 to 3, translation x, y, z at 4 to 6).
// The datapath is a five-stage pipeline: input register, nine parallel
// multiplier lanes, row sums, rounding, then shift, translation add and
// saturation. It takes one item per cycle while busy is low. out_valid rises
// when the item reaches the output register, after the multiplier lanes, row
// sums and rounding. Results are held for one cycle only and the receiver
// cannot stall them. Each quaternion write rebuilds the rotation matrix: the
// shared multiplier forms the ten products, a norm step sums the squares, then
// each of the nine entries takes setup, 33 divider steps and store; busy is high.
// A zero quaternion ends the build after the norm step.
// A zero quaternion sets quat_invalid on every result with zero coordinates.
// Reset loads the identity rotation and zero translation; busy is low after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_rigid_transform_macros.svh"

module point_rigid_transform #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [((COORD_WIDTH > 32) ? 6 : 5)-1:0] paddr,
    input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                                   pready,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [COORD_WIDTH-1:0]          point_x,
    input  logic signed [COORD_WIDTH-1:0]          point_y,
    input  logic signed [COORD_WIDTH-1:0]          point_z,
    output logic                                   out_valid,
    output logic signed [COORD_WIDTH-1:0]          out_x,
    output logic signed [COORD_WIDTH-1:0]          out_y,
    output logic signed [COORD_WIDTH-1:0]          out_z,
    output logic                                   quat_invalid
);
    import prt_pkg::*;

    localparam int DATA_W = (COORD_WIDTH > 32) ? 64 : 32;
    localparam int ADDR_W = (COORD_WIDTH > 32) ? 6 : 5;
    localparam int WSHIFT = (COORD_WIDTH > 32) ? 3 : 2;
    localparam int PH_W   = (COORD_WIDTH > 16) ? COORD_WIDTH - 16 : 1;
    localparam int HP_W   = PH_W + 32;
    localparam int LP_W   = 49;
    localparam int A_W    = HP_W + 2;
    localparam int B_W    = LP_W + 2;
    localparam int S_W    = COORD_WIDTH + 35;
    localparam int V_W    = S_W - 29;

    // Configuration port.
    logic [QUAT_W-1:0]      quat_reg [4];
    logic [COORD_WIDTH-1:0] trans_reg [3];
    logic                   cfg_we;
    reg_idx_t               cfg_idx;
    logic                   quat_we;
    quat_vec_t              quat_vec;
    mat_t                   mat;
    bld_status_t            bld_stat;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:WSHIFT]);
    assign quat_we = cfg_we && ((cfg_idx == REG_QUAT_X) || (cfg_idx == REG_QUAT_Y)
                             || (cfg_idx == REG_QUAT_Z) || (cfg_idx == REG_QUAT_W));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg[0]  <= '0;
            quat_reg[1]  <= '0;
            quat_reg[2]  <= '0;
            quat_reg[3]  <= QUAT_W'(ONE_Q30);
            trans_reg[0] <= '0;
            trans_reg[1] <= '0;
            trans_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_QUAT_X:  quat_reg[0]  <= pwdata[QUAT_W-1:0];
                REG_QUAT_Y:  quat_reg[1]  <= pwdata[QUAT_W-1:0];
                REG_QUAT_Z:  quat_reg[2]  <= pwdata[QUAT_W-1:0];
                REG_QUAT_W:  quat_reg[3]  <= pwdata[QUAT_W-1:0];
                REG_TRANS_X: trans_reg[0] <= pwdata[COORD_WIDTH-1:0];
                REG_TRANS_Y: trans_reg[1] <= pwdata[COORD_WIDTH-1:0];
                REG_TRANS_Z: trans_reg[2] <= pwdata[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_QUAT_X:  prdata = DATA_W'(quat_reg[0]);
            REG_QUAT_Y:  prdata = DATA_W'(quat_reg[1]);
            REG_QUAT_Z:  prdata = DATA_W'(quat_reg[2]);
            REG_QUAT_W:  prdata = DATA_W'(quat_reg[3]);
            REG_TRANS_X: prdata = DATA_W'(trans_reg[0]);
            REG_TRANS_Y: prdata = DATA_W'(trans_reg[1]);
            REG_TRANS_Z: prdata = DATA_W'(trans_reg[2]);
            default:     prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            quat_vec[i] = quat_reg[i];
        end
    end

    // The matrix builder owns the rotation matrix and the invalid flag.
    prt_mat_build u_build (
        .clk     (clk),
        .rst_n   (rst_n),
        .quat_we (quat_we),
        .quat    (quat_vec),
        .mat     (mat),
        .status  (bld_stat)
    );

    assign busy = bld_stat.busy;

    // Point pipeline. Valid bits are reset; payload registers are not.
    logic in_acc;
    logic s0_vld_reg, s1_vld_reg, s2_vld_reg, s3_vld_reg, out_vld_reg;

    logic signed [COORD_WIDTH-1:0] p_reg [3];
    logic signed [HP_W-1:0]        hp_reg [9];
    logic signed [LP_W-1:0]        lp_reg [9];
    logic signed [A_W-1:0]         a_reg [3];
    logic signed [B_W-1:0]         b_reg [3];
    logic signed [S_W-1:0]         s_reg [3];
    logic signed [COORD_WIDTH-1:0] o_reg [3];
    logic                          inv_reg;

    logic signed [PH_W-1:0]        ph [3];
    logic signed [16:0]            pl [3];
    logic signed [V_W-1:0]         v [3];
    logic signed [COORD_WIDTH-1:0] sat [3];

    assign in_acc = start && !busy;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            // Split each coordinate into a signed high part and an unsigned 16-bit low part.
            // The high part is the floor of the coordinate over 2^16.
            ph[j] = PH_W'(p_reg[j] >>> 16);
            pl[j] = $signed({1'b0, p_reg[j][15:0]});
        end
        for (int i = 0; i < 3; i++)
        begin
            // Round half up on the Q1.30 product, then add the translation.
            v[i] = V_W'(s_reg[i] >>> 30) + V_W'($signed(trans_reg[i]));
            if (v[i][V_W-1:COORD_WIDTH-1] == '0 || v[i][V_W-1:COORD_WIDTH-1] == '1)
            begin
                sat[i] = v[i][COORD_WIDTH-1:0];
            end
            else
            begin
                sat[i] = v[i][V_W-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                      : {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg  <= in_acc;
            s1_vld_reg  <= s0_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p_reg[0] <= point_x;
            p_reg[1] <= point_y;
            p_reg[2] <= point_z;
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                hp_reg[3*i+j] <= ph[j] * mat[3*i+j];
                lp_reg[3*i+j] <= pl[j] * mat[3*i+j];
            end
            a_reg[i] <= A_W'(hp_reg[3*i]) + A_W'(hp_reg[3*i+1]) + A_W'(hp_reg[3*i+2]);
            b_reg[i] <= B_W'(lp_reg[3*i]) + B_W'(lp_reg[3*i+1]) + B_W'(lp_reg[3*i+2]);
            s_reg[i] <= (S_W'(a_reg[i]) <<< 16) + S_W'(b_reg[i])
                      + $signed(S_W'(64'h2000_0000));
            o_reg[i] <= bld_stat.bad ? '0 : sat[i];
        end
        inv_reg <= bld_stat.bad;
    end

    assign out_valid    = out_vld_reg;
    assign out_x        = o_reg[0];
    assign out_y        = o_reg[1];
    assign out_z        = o_reg[2];
    assign quat_invalid = out_vld_reg && inv_reg;

    `PRT_ASSERT_NEXT(a_accept_enters, in_acc, s0_vld_reg, "accepted item did not enter the pipeline")
    `PRT_ASSERT_NEXT(a_s3_to_out, s3_vld_reg, out_valid, "result lost between rounding and output")
    `PRT_ASSERT_IMPLIES(a_invalid_zero, out_valid && quat_invalid, (out_x == '0) && (out_y == '0) && (out_z == '0), "invalid quaternion with nonzero output")

endmodule
